>>> src/tcs_screen_pkg.sv
// Shared types and constants for the caret-escape terminal screen.
`timescale 1ns / 1ps

package tcs_screen_pkg;

   localparam int ScreenSizeDefault = 10;
   localparam int CoordWidth        = 4;
   localparam int CharWidth         = 8;
   localparam logic [CharWidth-1:0] BlankChar = 8'h20;

   typedef struct packed {
      logic                  cmd;
      logic [CharWidth-1:0]  char_in;
      logic [CoordWidth-1:0] read_row;
      logic [CoordWidth-1:0] read_col;
   } req_type;

   typedef struct packed {
      logic [CharWidth-1:0]  cell_char;
      logic [CoordWidth-1:0] cursor_row_out;
      logic [CoordWidth-1:0] cursor_col_out;
      logic                  insert_mode_out;
   } rsp_type;

endpackage

>>> src/terminal_control_sequence_screen.sv
// Top level of the caret-escape terminal with its character screen.
//
// Usage:
//   Request channel (req_valid / req_ready / req_word) carries one byte per word:
//   cmd 0 feeds char_in to the terminal, cmd 1 only reads a cell. Every request
//   word yields exactly one response word on rsp_valid / rsp_ready / rsp_word,
//   reporting the cell at read_row, read_col after the byte took effect, plus
//   the cursor position and the insert mode.
//   Path: an accepted word is held in the input register, processed once the
//   response register is free, and offered on rsp_word from that register.
//   Throughput: one word per cycle unless the receiver stalls; each byte's screen
//   update is combinational logic on the SCREEN_SIZE x SCREEN_SIZE cell registers.
//   Reset: synchronous; every cell becomes a space, cursor goes home,
//   overwrite mode, no escape sequence pending, both pipeline stages empty.
//   Receiver stall: the response register holds its word; the input register
//   keeps one more word, after which req_ready drops until rsp_ready returns.
`timescale 1ns / 1ps

module terminal_control_sequence_screen #(
   parameter int SCREEN_SIZE = tcs_screen_pkg::ScreenSizeDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tcs_screen_pkg::req_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tcs_screen_pkg::rsp_type rsp_word
);

   localparam int CW = tcs_screen_pkg::CoordWidth;
   localparam int DW = tcs_screen_pkg::CharWidth;
   localparam int IdxW = (SCREEN_SIZE > 1) ? $clog2(SCREEN_SIZE) : 1;
   localparam logic [CW-1:0] LastPos = CW'(SCREEN_SIZE - 1);
   localparam logic [CW-1:0] SizePos = CW'(SCREEN_SIZE);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_CMD   = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;

   localparam logic [DW-1:0] CH_CARET = 8'h5E;
   localparam logic [DW-1:0] CH_B     = 8'h62;
   localparam logic [DW-1:0] CH_C     = 8'h63;
   localparam logic [DW-1:0] CH_D     = 8'h64;
   localparam logic [DW-1:0] CH_E     = 8'h65;
   localparam logic [DW-1:0] CH_H     = 8'h68;
   localparam logic [DW-1:0] CH_I     = 8'h69;
   localparam logic [DW-1:0] CH_L     = 8'h6C;
   localparam logic [DW-1:0] CH_O     = 8'h6F;
   localparam logic [DW-1:0] CH_R     = 8'h72;
   localparam logic [DW-1:0] CH_U     = 8'h75;
   localparam logic [DW-1:0] CH_ZERO  = 8'h30;
   localparam logic [DW-1:0] CH_NINE  = 8'h39;

   logic                    in_valid_ff;
   tcs_screen_pkg::req_type in_ff;
   logic                    rsp_valid_ff;
   tcs_screen_pkg::rsp_type rsp_ff;
   tcs_screen_pkg::rsp_type rsp_in;
   logic                    advance;

   logic [DW-1:0] screen_ff [SCREEN_SIZE][SCREEN_SIZE];
   logic [DW-1:0] screen_in [SCREEN_SIZE][SCREEN_SIZE];
   logic [CW-1:0] cursor_row_ff, cursor_row_in;
   logic [CW-1:0] cursor_col_ff, cursor_col_in;
   logic          insert_ff, insert_in;
   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] pending_row_ff, pending_row_in;

   logic          do_put, do_clear, do_erase;
   logic          is_digit;
   logic [CW-1:0] digit_sat;
   logic [DW-1:0] ch;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign ch        = in_ff.char_in;
   assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign digit_sat = (ch[CW-1:0] > LastPos) ? LastPos : ch[CW-1:0];

   always_comb begin
      cursor_row_in  = cursor_row_ff;
      cursor_col_in  = cursor_col_ff;
      insert_in      = insert_ff;
      phase_in       = phase_ff;
      pending_row_in = pending_row_ff;
      do_put         = 1'b0;
      do_clear       = 1'b0;
      do_erase       = 1'b0;
      if (!in_ff.cmd) begin
         case (phase_ff)
            PH_CMD: begin
               phase_in = PH_IDLE;
               case (ch)
                  CH_B: cursor_col_in = '0;
                  CH_C: do_clear = 1'b1;
                  CH_D: if (cursor_row_ff < LastPos) cursor_row_in = cursor_row_ff + 1'b1;
                  CH_U: if (cursor_row_ff != '0) cursor_row_in = cursor_row_ff - 1'b1;
                  CH_L: if (cursor_col_ff != '0) cursor_col_in = cursor_col_ff - 1'b1;
                  CH_R: if (cursor_col_ff < LastPos) cursor_col_in = cursor_col_ff + 1'b1;
                  CH_E: do_erase = 1'b1;
                  CH_H: begin
                     cursor_row_in = '0;
                     cursor_col_in = '0;
                  end
                  CH_I: insert_in = 1'b1;
                  CH_O: insert_in = 1'b0;
                  CH_CARET: do_put = 1'b1;
                  default: begin
                     if (is_digit) begin
                        pending_row_in = digit_sat;
                        phase_in       = PH_DIGIT;
                     end
                  end
               endcase
            end
            PH_DIGIT: begin
               phase_in = PH_IDLE;
               if (is_digit) begin
                  cursor_row_in = pending_row_ff;
                  cursor_col_in = digit_sat;
               end
            end
            default: begin
               if (ch == CH_CARET) begin
                  phase_in = PH_CMD;
               end else begin
                  do_put = 1'b1;
               end
            end
         endcase
         if (do_put && (cursor_col_ff < LastPos)) begin
            cursor_col_in = cursor_col_ff + 1'b1;
         end
      end
   end

   for (genvar r = 0; r < SCREEN_SIZE; r++) begin : g_row
      for (genvar c = 0; c < SCREEN_SIZE; c++) begin : g_col
         logic row_hit;
         logic [DW-1:0] left_cell;
         assign row_hit = (cursor_row_ff == CW'(r));
         if (c > 0) begin : g_left
            assign left_cell = screen_ff[r][c-1];
         end else begin : g_edge
            assign left_cell = screen_ff[r][c];
         end
         always_comb begin
            screen_in[r][c] = screen_ff[r][c];
            if (do_clear) begin
               screen_in[r][c] = tcs_screen_pkg::BlankChar;
            end else if (do_erase && row_hit && (CW'(c) >= cursor_col_ff)) begin
               screen_in[r][c] = tcs_screen_pkg::BlankChar;
            end else if (do_put && row_hit && (CW'(c) == cursor_col_ff)) begin
               screen_in[r][c] = ch;
            end else if (do_put && insert_ff && row_hit && (CW'(c) > cursor_col_ff)) begin
               screen_in[r][c] = left_cell;
            end
         end
      end
   end

   always_comb begin
      rsp_in.cursor_row_out  = cursor_row_in;
      rsp_in.cursor_col_out  = cursor_col_in;
      rsp_in.insert_mode_out = insert_in;
      if ((in_ff.read_row < SizePos) && (in_ff.read_col < SizePos)) begin
         rsp_in.cell_char = screen_in[in_ff.read_row[IdxW-1:0]][in_ff.read_col[IdxW-1:0]];
      end else begin
         rsp_in.cell_char = tcs_screen_pkg::BlankChar;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cursor_row_ff  <= '0;
         cursor_col_ff  <= '0;
         insert_ff      <= 1'b0;
         phase_ff       <= PH_IDLE;
         pending_row_ff <= '0;
         for (int r = 0; r < SCREEN_SIZE; r++) begin
            for (int c = 0; c < SCREEN_SIZE; c++) begin
               screen_ff[r][c] <= tcs_screen_pkg::BlankChar;
            end
         end
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            cursor_row_ff  <= cursor_row_in;
            cursor_col_ff  <= cursor_col_in;
            insert_ff      <= insert_in;
            phase_ff       <= phase_in;
            pending_row_ff <= pending_row_in;
            screen_ff      <= screen_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_word;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   a_row_range : assert property (@(posedge clock) disable iff (reset)
      cursor_row_ff < SizePos)
      else $error("cursor row beyond screen");

   a_col_range : assert property (@(posedge clock) disable iff (reset)
      cursor_col_ff < SizePos)
      else $error("cursor column beyond screen");

   a_read_only : assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.cmd |=> $stable(cursor_row_ff) && $stable(cursor_col_ff)
         && $stable(insert_ff) && $stable(phase_ff))
      else $error("read-only word changed terminal state");

   a_rsp_cursor : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_ff.cursor_row_out == cursor_row_ff
         && rsp_ff.cursor_col_out == cursor_col_ff
         && rsp_ff.insert_mode_out == insert_ff)
      else $error("response word disagrees with cursor state");

   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request stalled with room in the pipeline");

endmodule

>>> tb/tb_terminal_control_sequence_screen.sv
// Self-checking testbench for the caret-escape terminal screen, with a built-in predictor.
`timescale 1ns / 1ps

module tb_terminal_control_sequence_screen;

   localparam int Size        = tcs_screen_pkg::ScreenSizeDefault;
   localparam int HalfPeriod  = 6;
   localparam int ResetCycles = 10;
   localparam int RandomWords = 1350;
   localparam int HoldCycles  = 80;
   localparam int DrainLimit  = 20000;
   localparam int TailCycles  = 20;
   localparam int TimeoutNs   = 5_000_000;

   localparam logic CmdFeed = 1'b0;
   localparam logic CmdRead = 1'b1;

   localparam logic [7:0] KeyCaret     = "^";
   localparam logic [7:0] KeyColZero   = "b";
   localparam logic [7:0] KeyClear     = "c";
   localparam logic [7:0] KeyDown      = "d";
   localparam logic [7:0] KeyUp        = "u";
   localparam logic [7:0] KeyLeft      = "l";
   localparam logic [7:0] KeyRight     = "r";
   localparam logic [7:0] KeyErase     = "e";
   localparam logic [7:0] KeyHome      = "h";
   localparam logic [7:0] KeyInsert    = "i";
   localparam logic [7:0] KeyOverwrite = "o";
   localparam logic [7:0] KeyUnknown   = "z";
   localparam logic [7:0] DigitZero    = "0";
   localparam logic [7:0] DigitNine    = "9";

   typedef enum logic [1:0] {EscIdle, EscCaret, EscDigit} esc_state_type;

   typedef struct {
      tcs_screen_pkg::req_type word;
      bit                      typed;
      tcs_screen_pkg::rsp_type want;
   } script_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   tcs_screen_pkg::req_type req_word;
   logic                    rsp_valid;
   logic                    rsp_ready;
   tcs_screen_pkg::rsp_type rsp_word;

   logic [7:0]    cells [Size*Size];
   logic [3:0]    cur_row;
   logic [3:0]    cur_col;
   logic          ins_on;
   esc_state_type esc;
   logic [3:0]    row_latch;

   tcs_screen_pkg::rsp_type screen_reports [$];
   script_row_type          script_q [$];
   tcs_screen_pkg::rsp_type want_word;
   int                      words_sent;
   int                      reports_checked;
   int                      errors;
   int                      hold_asks;
   int                      hold_done;
   bit                      steady;

   terminal_control_sequence_screen #(.SCREEN_SIZE(Size)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   initial begin
      #(TimeoutNs);
      $display("status: fail");
      $finish;
   end

   function automatic void clear_screen_model();
      foreach (cells[i]) cells[i] = tcs_screen_pkg::BlankChar;
      cur_row   = '0;
      cur_col   = '0;
      ins_on    = 1'b0;
      esc       = EscIdle;
      row_latch = '0;
   endfunction

   function automatic bit is_digit(logic [7:0] ch);
      return ch >= DigitZero && ch <= DigitNine;
   endfunction

   function automatic logic [3:0] clip_coord(logic [7:0] d);
      return (d > Size - 1) ? 4'(Size - 1) : d[3:0];
   endfunction

   function automatic void put_cell(logic [7:0] ch);
      int k;
      if (ins_on) begin
         for (k = Size - 1; k > cur_col; k--)
            cells[cur_row*Size + k] = cells[cur_row*Size + k - 1];
      end
      cells[cur_row*Size + cur_col] = ch;
      if (cur_col < Size - 1) cur_col++;
   endfunction

   function automatic tcs_screen_pkg::rsp_type predict_screen(tcs_screen_pkg::req_type w);
      tcs_screen_pkg::rsp_type r;
      logic [7:0]              ch;
      int                      k;
      ch = w.char_in;
      if (w.cmd == CmdFeed) begin
         if (esc == EscCaret) begin
            esc = EscIdle;
            case (ch)
               KeyColZero:   cur_col = '0;
               KeyClear:     foreach (cells[i]) cells[i] = tcs_screen_pkg::BlankChar;
               KeyDown:      if (cur_row < Size - 1) cur_row++;
               KeyUp:        if (cur_row > 0) cur_row--;
               KeyLeft:      if (cur_col > 0) cur_col--;
               KeyRight:     if (cur_col < Size - 1) cur_col++;
               KeyErase: begin
                  for (k = cur_col; k < Size; k++)
                     cells[cur_row*Size + k] = tcs_screen_pkg::BlankChar;
               end
               KeyHome: begin
                  cur_row = '0;
                  cur_col = '0;
               end
               KeyInsert:    ins_on = 1'b1;
               KeyOverwrite: ins_on = 1'b0;
               KeyCaret:     put_cell(KeyCaret);
               default: begin
                  if (is_digit(ch)) begin
                     row_latch = clip_coord(ch - DigitZero);
                     esc = EscDigit;
                  end
               end
            endcase
         end else if (esc == EscDigit) begin
            esc = EscIdle;
            if (is_digit(ch)) begin
               cur_row = row_latch;
               cur_col = clip_coord(ch - DigitZero);
            end
         end else if (ch == KeyCaret) begin
            esc = EscCaret;
         end else begin
            put_cell(ch);
         end
      end
      if (w.read_row < Size && w.read_col < Size)
         r.cell_char = cells[w.read_row*Size + w.read_col];
      else
         r.cell_char = tcs_screen_pkg::BlankChar;
      r.cursor_row_out  = cur_row;
      r.cursor_col_out  = cur_col;
      r.insert_mode_out = ins_on;
      return r;
   endfunction

   function automatic tcs_screen_pkg::rsp_type report(logic [7:0] ch, logic [3:0] row,
                                                      logic [3:0] col, logic ins);
      tcs_screen_pkg::rsp_type r;
      r.cell_char       = ch;
      r.cursor_row_out  = row;
      r.cursor_col_out  = col;
      r.insert_mode_out = ins;
      return r;
   endfunction

   function automatic script_row_type step_row(logic cmd, logic [7:0] ch, logic [3:0] rr,
                                               logic [3:0] rc, bit typed = 1'b0,
                                               tcs_screen_pkg::rsp_type want = '0);
      script_row_type s;
      s.word.cmd      = cmd;
      s.word.char_in  = ch;
      s.word.read_row = rr;
      s.word.read_col = rc;
      s.typed         = typed;
      s.want          = want;
      return s;
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return 0;
      if (sel < 85) return $urandom_range(1, 3);
      if (sel < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   task automatic feed_word(input tcs_screen_pkg::req_type w, input int gap, input bit typed,
                            input tcs_screen_pkg::rsp_type want);
      tcs_screen_pkg::rsp_type predicted;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      predicted = predict_screen(w);
      screen_reports.push_back(typed ? want : predicted);
      words_sent++;
   endtask

   task automatic idle_input();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_byte(input logic cmd, input logic [7:0] ch);
      tcs_screen_pkg::req_type w;
      int                      sel;
      w.cmd     = cmd;
      w.char_in = ch;
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
         w.read_row = cur_row;
         w.read_col = 4'($urandom_range(0, Size - 1));
      end else if (sel < 85) begin
         w.read_row = 4'($urandom_range(0, Size - 1));
         w.read_col = 4'($urandom_range(0, Size - 1));
      end else begin
         w.read_row = 4'($urandom_range(0, 15));
         w.read_col = 4'($urandom_range(0, 15));
      end
      feed_word(w, steady ? 0 : pick_gap(), 1'b0, '0);
   endtask

   task automatic send_phrase();
      int         sel;
      logic [7:0] key;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         send_byte(CmdFeed, 8'($urandom_range(0, 255)));
      end else if (sel < 65) begin
         case ($urandom_range(0, 9))
            0:       key = KeyColZero;
            1:       key = KeyDown;
            2:       key = KeyUp;
            3:       key = KeyLeft;
            4:       key = KeyRight;
            5:       key = KeyErase;
            6:       key = KeyHome;
            7:       key = KeyInsert;
            8:       key = KeyOverwrite;
            default: key = KeyCaret;
         endcase
         send_byte(CmdFeed, KeyCaret);
         send_byte(CmdFeed, key);
      end else if (sel < 80) begin
         send_byte(CmdFeed, KeyCaret);
         send_byte(CmdFeed, DigitZero + 8'($urandom_range(0, 9)));
         send_byte(CmdFeed, DigitZero + 8'($urandom_range(0, 9)));
      end else if (sel < 83) begin
         send_byte(CmdFeed, KeyCaret);
         send_byte(CmdFeed, KeyClear);
      end else if (sel < 90) begin
         send_byte(CmdFeed, KeyCaret);
         if ($urandom_range(0, 1) == 0)
            send_byte(CmdFeed, DigitZero + 8'($urandom_range(0, 9)));
         send_byte(CmdFeed, 8'($urandom_range(0, 255)));
      end else begin
         send_byte(CmdRead, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_drained();
      int n;
      idle_input();
      for (n = 0; n < DrainLimit && screen_reports.size() != 0; n++) @(posedge clock);
   endtask

   // receiver: random stalls, long ready stretches, and one long hold-off
   initial begin
      int span;
      rsp_ready = 1'b0;
      forever begin
         if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            repeat (HoldCycles) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end else begin
            span = pick_gap();
            repeat (span) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end
         span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         repeat (span) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (screen_reports.size() == 0) begin
            $error("response word with nothing expected: %h", rsp_word);
            errors++;
         end else begin
            want_word = screen_reports.pop_front();
            reports_checked++;
            if (rsp_word.cell_char !== want_word.cell_char) begin
               $error("cell_char expected %02h got %02h",
                      want_word.cell_char, rsp_word.cell_char);
               errors++;
            end
            if (rsp_word.cursor_row_out !== want_word.cursor_row_out) begin
               $error("cursor_row_out expected %0d got %0d",
                      want_word.cursor_row_out, rsp_word.cursor_row_out);
               errors++;
            end
            if (rsp_word.cursor_col_out !== want_word.cursor_col_out) begin
               $error("cursor_col_out expected %0d got %0d",
                      want_word.cursor_col_out, rsp_word.cursor_col_out);
               errors++;
            end
            if (rsp_word.insert_mode_out !== want_word.insert_mode_out) begin
               $error("insert_mode_out expected %0d got %0d",
                      want_word.insert_mode_out, rsp_word.insert_mode_out);
               errors++;
            end
         end
      end
   end

   initial begin
      int  random_start;
      bit  held;
      bit  paused;
      int  k;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_word        = '0;
      words_sent      = 0;
      reports_checked = 0;
      errors          = 0;
      hold_asks       = 0;
      hold_done       = 0;
      steady          = 1'b0;
      held            = 1'b0;
      paused          = 1'b0;
      clear_screen_model();

      script_q.push_back(step_row(CmdRead, 8'h00, 0, 0, 1'b1,
                                  report(tcs_screen_pkg::BlankChar, 0, 0, 0)));
      script_q.push_back(step_row(CmdRead, 8'hFF, 15, 15, 1'b1,
                                  report(tcs_screen_pkg::BlankChar, 0, 0, 0)));
      script_q.push_back(step_row(CmdFeed, "A", 0, 0, 1'b1, report("A", 0, 1, 0)));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 0, 0));
      script_q.push_back(step_row(CmdFeed, DigitNine, 0, 0));
      script_q.push_back(step_row(CmdFeed, DigitNine, 9, 9, 1'b1,
                                  report(tcs_screen_pkg::BlankChar, 9, 9, 0)));
      script_q.push_back(step_row(CmdFeed, 8'hFF, 9, 9));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 9, 9));
      script_q.push_back(step_row(CmdFeed, KeyInsert, 9, 9));
      script_q.push_back(step_row(CmdFeed, 8'h00, 9, 8));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 9, 9));
      script_q.push_back(step_row(CmdFeed, KeyHome, 0, 0));
      script_q.push_back(step_row(CmdFeed, "B", 0, 1));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 0, 1));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 0, 2));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 0, 2));
      script_q.push_back(step_row(CmdFeed, KeyErase, 0, 3));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 0, 0));
      script_q.push_back(step_row(CmdFeed, KeyOverwrite, 0, 0));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 0, 1));
      script_q.push_back(step_row(CmdFeed, KeyUnknown, 0, 1));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 0, 0));
      script_q.push_back(step_row(CmdFeed, "5", 0, 0));
      script_q.push_back(step_row(CmdFeed, "x", 0, 1));
      script_q.push_back(step_row(CmdFeed, KeyCaret, 0, 0));
      script_q.push_back(step_row(CmdFeed, KeyClear, 0, 0));

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script_q[i])
         feed_word(script_q[i].word, pick_gap(), script_q[i].typed, script_q[i].want);

      random_start = words_sent;
      while (words_sent - random_start < RandomWords) begin
         steady = ((words_sent % 200) < 50);
         if (!held && words_sent - random_start > 400) begin
            // stall the receiver and keep offering words until the input backs up
            held = 1'b1;
            hold_asks++;
            idle_input();
            while (hold_done != hold_asks) @(posedge clock);
            steady = 1'b1;
            for (k = 0; k < 30; k++) send_phrase();
         end else if (!paused && words_sent - random_start > 900) begin
            paused = 1'b1;
            wait_drained();
         end
         send_phrase();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (TailCycles) @(posedge clock);
      if (screen_reports.size() != 0) begin
         $error("%0d expected responses never arrived", screen_reports.size());
         errors++;
      end

      $display("sent %0d words, checked %0d responses", words_sent, reports_checked);
      $display("covered text, every caret command, digit moves, broken escapes, reads");
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
src/tcs_screen_pkg.sv
src/terminal_control_sequence_screen.sv
tb/tb_terminal_control_sequence_screen.sv
